FILE: rtl/gcu_pkg.sv
// Shared constants, codes and types of the greedy graph coloring unit.
package gcu_pkg;

   localparam int GCU_VERTICES = 64;
   localparam int VIDX_W       = 6;
   localparam int COLOR_W      = 7;
   localparam int OP_W         = 2;

   typedef logic [VIDX_W-1:0]  vidx_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [OP_W-1:0]    op_type;

   localparam op_type OP_ADD_EDGE = 2'd0;
   localparam op_type OP_COLOR    = 2'd1;
   localparam op_type OP_CLEAR    = 2'd2;

endpackage

FILE: rtl/gcu_ram.sv
// Generic single-write, single-read RAM with bit write mask and registered read.
module gcu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (wr_mask[i]) begin
               mem[wr_addr][i] <= wr_data[i];
            end
         end
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/greedy_graph_coloring_unit.sv
// Greedy first-fit graph coloring unit: edge store, sequencer and result port.
//
// Usage: an item is taken on req_* when start is high and busy is low.
//   add edge (operation 0): written directly, busy stays low, so edges
//     can stream in one beat per cycle. Edge (a,b) lands in row max(a,b),
//     bit min(a,b) of the adjacency RAM; only that lower triangle is read.
//   clear (operation 2): drops all rows at once through the
//     per-row valid bits. Operation 3 is ignored.
//   color (operation 1): colors vertices 0 .. min(vertex_count,64)-1 and
//     emits one rsp beat per vertex, rsp_last_of_run on the final one.
//     Vertex u takes a row read, a scan with one color RAM read per lower
//     vertex (shared taken-set update), a drain step when u > 0 and a
//     first-fit search of eight colors per cycle. The scan is paced by the
//     single color RAM read port. busy is high for the whole run.
// Results: each rsp beat is held for exactly one cycle under rsp_valid;
//   the receiver cannot stall. The last beat shows in the cycle busy falls.
// Config: csr_wr_en/csr_wr_data write vertex_count (taken at run start);
//   write only while idle. A count of zero gives no beats.
// Reset: synchronous, active high. Adjacency is empty right away (valid
//   bits cleared, no sweep), vertex_count returns to 64.
module greedy_graph_coloring_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gcu_pkg::op_type     req_operation,
   input  gcu_pkg::vidx_type   req_first_vertex,
   input  gcu_pkg::vidx_type   req_second_vertex,
   output logic                rsp_valid,
   output gcu_pkg::vidx_type   rsp_vertex_index,
   output gcu_pkg::color_type  rsp_assigned_color,
   output logic                rsp_last_of_run,
   input  logic                csr_wr_en,
   input  gcu_pkg::color_type  csr_wr_data
);

   import gcu_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROW    = 3'd1;  // row u read in flight
   localparam logic [2:0] ST_SCAN   = 3'd2;  // walk v = 0 .. u-1
   localparam logic [2:0] ST_DRAIN  = 3'd3;  // last color read returns
   localparam logic [2:0] ST_SEARCH = 3'd4;  // first free color, 8 per step

   logic [2:0]              state_ff, state_in;
   vidx_type                u_ff, u_in;
   vidx_type                v_ff, v_in;
   vidx_type                last_u_ff, last_u_in;
   logic                    pend_ff, pend_in;
   logic [GCU_VERTICES-1:0] taken_ff, taken_in;
   logic [2:0]              k_ff, k_in;
   logic [GCU_VERTICES-1:0] row_valid_ff, row_valid_in;
   color_type               vcount_ff, vcount_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   vidx_type                rsp_vidx_ff, rsp_vidx_in;
   color_type               rsp_color_ff, rsp_color_in;
   logic                    rsp_last_ff, rsp_last_in;

   // adjacency RAM
   logic                    adj_wr_en;
   vidx_type                adj_wr_addr;
   logic [GCU_VERTICES-1:0] adj_wr_data, adj_wr_mask, adj_rd_data;

   // color RAM
   logic                    col_wr_en;
   color_type               col_wr_data, col_rd_data;
   vidx_type                col_idx;

   // edge and search helpers
   vidx_type                edge_hi, edge_lo;
   color_type               run_count;
   logic [GCU_VERTICES-1:0] search_word;
   logic [7:0]              chunk_free;
   logic [2:0]              chunk_enc;
   logic                    search_hit;
   color_type               pick;

   gcu_ram #(.WIDTH(GCU_VERTICES), .DEPTH(GCU_VERTICES)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .wr_mask (adj_wr_mask),
      .rd_addr (u_ff),
      .rd_data (adj_rd_data)
   );

   gcu_ram #(.WIDTH(COLOR_W), .DEPTH(GCU_VERTICES)) u_color_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (u_ff),
      .wr_data (col_wr_data),
      .wr_mask ('1),
      .rd_addr (v_ff),
      .rd_data (col_rd_data)
   );

   // lower triangle placement of an edge
   assign edge_hi = (req_first_vertex > req_second_vertex) ? req_first_vertex
                                                          : req_second_vertex;
   assign edge_lo = (req_first_vertex > req_second_vertex) ? req_second_vertex
                                                          : req_first_vertex;

   assign run_count = (vcount_ff > COLOR_W'(GCU_VERTICES)) ? COLOR_W'(GCU_VERTICES)
                                                           : vcount_ff;

   assign col_idx = VIDX_W'(col_rd_data - COLOR_W'(1));

   // color 64 is the fallback, so its taken bit never blocks the search
   always_comb begin
      search_word = taken_ff;
      search_word[GCU_VERTICES-1] = 1'b0;
      chunk_free = ~search_word[{k_ff, 3'b000} +: 8];
      chunk_enc = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (chunk_free[i]) begin
            chunk_enc = 3'(i);
         end
      end
      search_hit = |chunk_free;
      pick = COLOR_W'({k_ff, chunk_enc}) + COLOR_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      last_u_in    = last_u_ff;
      pend_in      = 1'b0;
      taken_in     = taken_ff;
      k_in         = k_ff;
      row_valid_in = row_valid_ff;
      vcount_in    = csr_wr_en ? csr_wr_data : vcount_ff;
      rsp_valid_in = 1'b0;
      rsp_vidx_in  = rsp_vidx_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      adj_wr_en    = 1'b0;
      adj_wr_addr  = edge_hi;
      adj_wr_data  = GCU_VERTICES'(1) << edge_lo;
      adj_wr_mask  = row_valid_ff[edge_hi] ? adj_wr_data : '1;
      col_wr_en    = 1'b0;
      col_wr_data  = pick;

      // a neighbor's color read issued last cycle marks the taken set
      if (pend_ff) begin
         taken_in[col_idx] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  OP_ADD_EDGE: begin
                     adj_wr_en = 1'b1;
                     row_valid_in[edge_hi] = 1'b1;
                  end
                  OP_CLEAR: begin
                     row_valid_in = '0;
                  end
                  OP_COLOR: begin
                     if (run_count != '0) begin
                        u_in      = '0;
                        last_u_in = VIDX_W'(run_count - COLOR_W'(1));
                        state_in  = ST_ROW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROW: begin
            taken_in = '0;
            v_in     = '0;
            k_in     = '0;
            state_in = (u_ff == '0) ? ST_SEARCH : ST_SCAN;
         end
         ST_SCAN: begin
            pend_in = row_valid_ff[u_ff] & adj_rd_data[v_ff];
            if (v_ff == u_ff - VIDX_W'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               v_in = v_ff + VIDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_hit) begin
               col_wr_en    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_vidx_in  = u_ff;
               rsp_color_in = pick;
               rsp_last_in  = (u_ff == last_u_ff);
               if (u_ff == last_u_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  u_in     = u_ff + VIDX_W'(1);
                  state_in = ST_ROW;
               end
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         row_valid_ff <= '0;
         vcount_ff    <= COLOR_W'(GCU_VERTICES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         row_valid_ff <= row_valid_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff         <= u_in;
      v_ff         <= v_in;
      last_u_ff    <= last_u_in;
      taken_ff     <= taken_in;
      k_ff         <= k_in;
      rsp_vidx_ff  <= rsp_vidx_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_vertex_index   = rsp_vidx_ff;
   assign rsp_assigned_color = rsp_color_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   // a beat only comes out of a run in progress
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a coloring run");

   // first fit never exceeds one more than the vertex index
   a_color_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_assigned_color != '0) &&
                    (rsp_assigned_color <= COLOR_W'(rsp_vertex_index) + COLOR_W'(1)))
      else $error("assigned color out of first-fit bound");

   // the last search chunk always yields a color
   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) && (k_ff == 3'd7) |-> search_hit)
      else $error("first-fit search ran past the last chunk");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the greedy first-fit graph coloring unit.
module tb_top;
   import gcu_pkg::*;

   // Operation code 3 is not used by the block; it must be ignored.
   localparam op_type OP_UNUSED = 2'd3;
   // Vertices joined into one clique by the complete graph test.
   localparam int CLIQUE_SIZE = 12;

   // One expected result beat of a color run.
   typedef struct {
      vidx_type  vertex;
      color_type color;
      logic      last;
   } color_beat_type;

   logic      clock;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   op_type    req_operation = OP_ADD_EDGE;
   vidx_type  req_first_vertex = '0;
   vidx_type  req_second_vertex = '0;
   logic      rsp_valid;
   vidx_type  rsp_vertex_index;
   color_type rsp_assigned_color;
   logic      rsp_last_of_run;
   logic      csr_wr_en = 1'b0;
   color_type csr_wr_data = '0;

   // Mirror of the block's state: lower and upper triangle both kept, the
   // walk only looks at neighbors below the current vertex.
   logic [GCU_VERTICES-1:0] adjacency [GCU_VERTICES];
   color_type               vertex_colors [GCU_VERTICES];
   color_type               vertex_cfg = 7'd64;   // reset value of the register

   color_beat_type expected_colors [$];
   int             errors = 0;

   greedy_graph_coloring_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_first_vertex   (req_first_vertex),
      .req_second_vertex  (req_second_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_vertex_index   (rsp_vertex_index),
      .rsp_assigned_color (rsp_assigned_color),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #100000000;
      $display("greedy_graph_coloring_unit test failed");
      $finish;
   end

   function automatic void clear_edges();
      for (int i = 0; i < GCU_VERTICES; i++) begin
         adjacency[i] = '0;
      end
   endfunction

   // Updates the mirrored state for one accepted item and queues the
   // beats that a color command must produce.
   function automatic void apply_item(op_type op, vidx_type a, vidx_type b);
      int                           n;
      int                           pick;
      logic [(1<<COLOR_W)-1:0]      taken;
      color_beat_type               beat;
      case (op)
         OP_ADD_EDGE: begin
            adjacency[a][b] = 1'b1;
            adjacency[b][a] = 1'b1;
         end
         OP_CLEAR: begin
            clear_edges();
         end
         OP_COLOR: begin
            // counts above the vertex limit are clipped, zero colors nothing
            n = (vertex_cfg > GCU_VERTICES) ? GCU_VERTICES : vertex_cfg;
            for (int u = 0; u < n; u++) begin
               taken = '0;
               for (int v = 0; v < u; v++) begin
                  if (adjacency[u][v]) taken[vertex_colors[v]] = 1'b1;
               end
               // first fit, saturating at the top color
               pick = 1;
               while (pick < GCU_VERTICES && taken[pick]) pick++;
               vertex_colors[u] = COLOR_W'(pick);
               beat.vertex = VIDX_W'(u);
               beat.color  = COLOR_W'(pick);
               beat.last   = (u == n - 1);
               expected_colors.insert(expected_colors.size(), beat);
            end
         end
         default: ;
      endcase
   endfunction

   // Presents one item and holds it until the block takes it. start is
   // left high so the next item can follow back to back.
   task automatic send_item(input op_type op, input vidx_type a, input vidx_type b);
      start             <= 1'b1;
      req_operation     <= op;
      req_first_vertex  <= a;
      req_second_vertex <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_item(op, a, b);
   endtask

   // Random sender gap: mostly none, some short, a few long.
   task automatic idle_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 60) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stops sending until every expected beat is in and the block is idle.
   // The extra wait covers a zero-count run, which gives no beat.
   task automatic drain_results();
      start <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Register write; only called with the block idle.
   task automatic write_vertex_count(input color_type value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      vertex_cfg   = value;
      @(posedge clock);
   endtask

   // Result checker: the block cannot be stalled, so every strobed beat
   // is compared against the oldest expectation at the edge that ends it.
   always @(posedge clock) begin : check_beats
      color_beat_type exp_beat;
      if (!reset && rsp_valid) begin
         if (expected_colors.size() == 0) begin
            $display("%0t unexpected beat: vertex %0d color %0d last %0d", $time,
                     rsp_vertex_index, rsp_assigned_color, rsp_last_of_run);
            errors++;
         end else begin
            exp_beat = expected_colors.pop_front();
            if (rsp_vertex_index !== exp_beat.vertex) begin
               $display("%0t vertex_index mismatch: expected %0d actual %0d", $time,
                        exp_beat.vertex, rsp_vertex_index);
               errors++;
            end
            if (rsp_assigned_color !== exp_beat.color) begin
               $display("%0t assigned_color mismatch (vertex %0d): expected %0d actual %0d",
                        $time, exp_beat.vertex, exp_beat.color, rsp_assigned_color);
               errors++;
            end
            if (rsp_last_of_run !== exp_beat.last) begin
               $display("%0t last_of_run mismatch (vertex %0d): expected %0d actual %0d",
                        $time, exp_beat.vertex, exp_beat.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // Runs on the reset value of the count (64): extreme endpoints, a
   // duplicate edge, a self-loop, a triangle and an ignored opcode.
   task automatic test_edge_extremes();
      send_item(OP_ADD_EDGE, 6'd0, 6'd63);
      send_item(OP_ADD_EDGE, 6'd63, 6'd0);     // duplicate, no change
      send_item(OP_ADD_EDGE, 6'd5, 6'd5);      // self-loop, no effect
      send_item(OP_ADD_EDGE, 6'd1, 6'd0);
      send_item(OP_ADD_EDGE, 6'd2, 6'd1);
      send_item(OP_ADD_EDGE, 6'd0, 6'd2);      // closes the triangle
      send_item(OP_UNUSED, 6'd3, 6'd1);        // must not add an edge
      send_item(OP_ADD_EDGE, 6'd62, 6'd63);
      send_item(OP_COLOR, 6'd0, 6'd0);
      drain_results();
   endtask

   // Clear drops every edge: everything goes back to color 1.
   task automatic test_clear_all();
      send_item(OP_CLEAR, 6'd0, 6'd0);
      send_item(OP_COLOR, 6'd0, 6'd0);
      write_vertex_count(7'd1);
      send_item(OP_ADD_EDGE, 6'd0, 6'd0);
      send_item(OP_COLOR, 6'd63, 6'd63);       // single beat, marked last
      drain_results();
   endtask

   // Counts of zero, one above the limit and the field maximum.
   task automatic test_count_limits();
      write_vertex_count(7'd0);
      send_item(OP_COLOR, 6'd0, 6'd0);         // no beat at all
      write_vertex_count(7'd127);
      send_item(OP_ADD_EDGE, 6'd42, 6'd21);
      send_item(OP_COLOR, 6'd21, 6'd42);
      write_vertex_count(7'd65);
      send_item(OP_COLOR, 6'd0, 6'd0);
      write_vertex_count(7'd2);
      send_item(OP_ADD_EDGE, 6'd1, 6'd0);
      send_item(OP_COLOR, 6'd0, 6'd0);
      drain_results();
   endtask

   // Clique on the lowest vertices, colors 1..CLIQUE_SIZE; the rest of the
   // full run gets color 1. Edges stream one beat per cycle bar rare gaps.
   task automatic test_complete_graph();
      write_vertex_count(7'd64);
      send_item(OP_CLEAR, 6'd0, 6'd0);
      for (int u = 1; u < CLIQUE_SIZE; u++) begin
         for (int v = 0; v < u; v++) begin
            if ($urandom_range(0, 1)) send_item(OP_ADD_EDGE, VIDX_W'(u), VIDX_W'(v));
            else send_item(OP_ADD_EDGE, VIDX_W'(v), VIDX_W'(u));
            if ($urandom_range(0, 99) < 3) idle_gap();
         end
      end
      send_item(OP_COLOR, 6'd0, 6'd0);
      drain_results();
   endtask

   // Random graphs: each phase picks a count, mostly small, loads a burst
   // of edges among the colored vertices with some noise, then colors.
   task automatic test_random_graphs();
      int        items_left;
      int        r;
      int        burst;
      int        span;
      int        quiet;
      color_type count;
      items_left = 64;
      while (items_left > 0) begin
         r = $urandom_range(0, 9);
         if (r == 0) count = 7'd64;
         else if (r == 1) count = COLOR_W'($urandom_range(65, 127));
         else count = COLOR_W'($urandom_range(1, 20));
         write_vertex_count(count);
         span  = (count > GCU_VERTICES) ? GCU_VERTICES : count;
         quiet = ($urandom_range(0, 9) < 3);   // phase with back-to-back beats
         if ($urandom_range(0, 2) == 0) begin
            send_item(OP_CLEAR, VIDX_W'($urandom_range(0, 63)),
                      VIDX_W'($urandom_range(0, 63)));
            items_left--;
         end
         burst = $urandom_range(4, 24);
         for (int i = 0; i < burst; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               send_item(OP_ADD_EDGE, VIDX_W'($urandom_range(0, span - 1)),
                         VIDX_W'($urandom_range(0, span - 1)));
               items_left--;
            end else if (r < 88) begin
               send_item(OP_ADD_EDGE, VIDX_W'($urandom_range(0, 63)),
                         VIDX_W'($urandom_range(0, 63)));
               items_left--;
            end else if (r < 94) begin
               send_item(OP_UNUSED, VIDX_W'($urandom_range(0, 63)),
                         VIDX_W'($urandom_range(0, 63)));
            end else if (r < 97) begin
               send_item(OP_COLOR, VIDX_W'($urandom_range(0, 63)),
                         VIDX_W'($urandom_range(0, 63)));
               items_left--;
            end else begin
               send_item(OP_CLEAR, VIDX_W'($urandom_range(0, 63)),
                         VIDX_W'($urandom_range(0, 63)));
               items_left--;
            end
            if (!quiet) idle_gap();
         end
         send_item(OP_COLOR, VIDX_W'($urandom_range(0, 63)),
                   VIDX_W'($urandom_range(0, 63)));
         items_left--;
         // sometimes recolor the same graph straight away
         if ($urandom_range(0, 3) == 0) begin
            send_item(OP_COLOR, VIDX_W'($urandom_range(0, 63)),
                      VIDX_W'($urandom_range(0, 63)));
            items_left--;
         end
         if (!quiet) idle_gap();
      end
      drain_results();
   endtask

   initial begin
      clear_edges();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_edge_extremes();
      test_clear_all();
      test_count_limits();
      test_complete_graph();
      test_random_graphs();
      drain_results();
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_colors.size() == 0) begin
         $display("greedy_graph_coloring_unit test passed");
      end else begin
         $display("greedy_graph_coloring_unit test failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/gcu_pkg.sv
rtl/gcu_ram.sv
rtl/greedy_graph_coloring_unit.sv
test/tb_top.sv
